FILE: sv/bhsp_pkg.sv
// Shared types and constants for the BMP header stream parser.
package bhsp_pkg;

    localparam int NUM_FIELDS = 7;

    localparam logic [2:0] FIELD_SIZE      = 3'd0;
    localparam logic [2:0] FIELD_OFFSET    = 3'd1;
    localparam logic [2:0] FIELD_HDRSIZE   = 3'd2;
    localparam logic [2:0] FIELD_WIDTH     = 3'd3;
    localparam logic [2:0] FIELD_HEIGHT    = 3'd4;
    localparam logic [2:0] FIELD_BITCOUNT  = 3'd5;
    localparam logic [2:0] FIELD_IMAGESIZE = 3'd6;

    // start offset and byte length of each header field, by field id
    localparam logic [31:0] START_OFFSET [NUM_FIELDS] = '{
        32'd2, 32'd10, 32'd14, 32'd18, 32'd22, 32'd28, 32'd34
    };
    localparam logic [2:0] FIELD_LEN [NUM_FIELDS] = '{
        3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd2, 3'd4
    };

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_FIELD = 2'd1,
        KIND_PIXEL = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_start;
    } t_in_item;

    typedef struct packed {
        t_kind       kind;
        logic [2:0]  field_id;
        logic [31:0] field_value;
        logic [7:0]  pixel_byte;
        logic [31:0] pixel_index;
        logic        last_pixel;
    } t_out_item;

endpackage

FILE: sv/bhsp_in_if.sv
// Valid/ready channel carrying raw file bytes.
interface bhsp_in_if;
    import bhsp_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: sv/bhsp_out_if.sv
// Valid/ready channel carrying parser results.
interface bhsp_out_if;
    import bhsp_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: sv/bmp_header_stream_parser_unit.sv
// BMP header stream parser: header field assembly and pixel byte pass-through.
// Each result is valid in the cycle after its byte transfer, and the result
// register frees as it is taken; one byte per cycle unless the output stalls,
// as the state registers update in a single pass from the accepted byte.
// Reset (synchronous, active low) clears all parse state and the result valid.
module bmp_header_stream_parser_unit (
    input logic        i_clk,
    input logic        i_rst_n,
    bhsp_in_if.sink    i_in,
    bhsp_out_if.source o_out
);
    import bhsp_pkg::*;

    logic [31:0] r_pos, n_pos;
    logic [31:0] r_asm, n_asm;
    logic [2:0]  r_field, n_field;
    logic [2:0]  r_left, n_left;
    logic [31:0] r_doff, n_doff;
    logic [31:0] r_size, n_size;
    logic [31:0] r_sent, n_sent;
    logic        r_content, n_content;
    t_out_item   r_out, n_out;
    logic        r_out_valid;

    // state as seen by this byte, after a new-file clear
    logic [31:0] c_pos, c_asm, c_doff, c_size, c_sent;
    logic [2:0]  c_field, c_left;
    logic        c_content;

    logic        in_fire;
    logic        can_start;
    logic        hit;
    logic        last;
    logic [2:0]  id;
    logic [2:0]  idx;
    logic [31:0] asm_val;
    logic [31:0] sent_inc;

    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_fire     = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_comb begin
        c_pos     = i_in.data.file_start ? '0 : r_pos;
        c_asm     = i_in.data.file_start ? '0 : r_asm;
        c_field   = i_in.data.file_start ? '0 : r_field;
        c_left    = i_in.data.file_start ? '0 : r_left;
        c_doff    = i_in.data.file_start ? '0 : r_doff;
        c_size    = i_in.data.file_start ? '0 : r_size;
        c_sent    = i_in.data.file_start ? '0 : r_sent;
        c_content = i_in.data.file_start ? 1'b0 : r_content;

        n_pos     = c_pos;
        n_asm     = c_asm;
        n_field   = c_field;
        n_left    = c_left;
        n_doff    = c_doff;
        n_size    = c_size;
        n_sent    = c_sent;
        n_content = c_content;
        n_out     = '0;
        n_out.kind = KIND_NONE;

        can_start = (c_pos != '1);
        if (can_start) begin
            n_pos = c_pos + 32'd1;
        end

        id       = (c_field < 3'(NUM_FIELDS)) ? c_field : FIELD_SIZE;
        idx      = FIELD_LEN[id] - c_left;
        asm_val  = c_asm | (32'(i_in.data.data_byte) << {idx[1:0], 3'b000});
        sent_inc = c_sent + 32'd1;
        last     = 1'b0;
        hit      = 1'b0;

        if (c_content) begin
            last              = (sent_inc == c_size);
            n_out.kind        = KIND_PIXEL;
            n_out.pixel_byte  = i_in.data.data_byte;
            n_out.pixel_index = c_sent;
            n_out.last_pixel  = last;
            n_sent            = sent_inc;
            if (last) begin
                n_content = 1'b0;
            end
        end else if (c_left != 3'd0) begin
            n_asm  = asm_val;
            n_left = c_left - 3'd1;
            if (c_left == 3'd1) begin
                if (c_field == FIELD_OFFSET) begin
                    n_doff = asm_val;
                end
                if (c_field == FIELD_IMAGESIZE) begin
                    n_size = asm_val;
                end
                n_out.kind        = KIND_FIELD;
                n_out.field_id    = c_field;
                n_out.field_value = asm_val;
            end
        end else if (can_start) begin
            // field start offsets are distinct, so at most one matches
            for (int k = 0; k < NUM_FIELDS; k++) begin
                if (c_pos == START_OFFSET[k]) begin
                    hit     = 1'b1;
                    n_field = 3'(k);
                    n_asm   = 32'(i_in.data.data_byte);
                    n_left  = FIELD_LEN[k] - 3'd1;
                end
            end
            if (!hit && c_pos == c_doff && c_size != 32'd0) begin
                last              = (c_size == 32'd1);
                n_out.kind        = KIND_PIXEL;
                n_out.pixel_byte  = i_in.data.data_byte;
                n_out.pixel_index = '0;
                n_out.last_pixel  = last;
                n_sent            = 32'd1;
                n_content         = !last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_asm       <= '0;
            r_field     <= '0;
            r_left      <= '0;
            r_doff      <= '0;
            r_size      <= '0;
            r_sent      <= '0;
            r_content   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_pos       <= n_pos;
                r_asm       <= n_asm;
                r_field     <= n_field;
                r_left      <= n_left;
                r_doff      <= n_doff;
                r_size      <= n_size;
                r_sent      <= n_sent;
                r_content   <= n_content;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out <= n_out;
        end
    end

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result valid after reset");

    a_none_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.kind == KIND_NONE) |->
            (o_out.data.field_value == '0 && o_out.data.pixel_index == '0 &&
             !o_out.data.last_pixel))
        else $error("empty result carries data");

    a_last_is_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.last_pixel) |-> (o_out.data.kind == KIND_PIXEL))
        else $error("last mark on non-pixel result");

    a_field_id_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left != 3'd0) |-> (r_field < 3'(NUM_FIELDS) && !r_content))
        else $error("field assembly overlaps pixel run");

endmodule

FILE: test/bmp_header_stream_parser_unit_checker.sv
// Checker for the BMP header stream parser: watches both channels, predicts results, compares.
module bmp_header_stream_parser_unit_checker
    import bhsp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_field_count,
    output int        o_pixel_count
);

    localparam logic [31:0] POS_SATURATED = 32'hFFFF_FFFF;
    localparam int          PRINT_CAP     = 30;

    // predicted parser state
    logic [31:0] byte_pos;
    logic [31:0] field_acc;
    logic [2:0]  cur_field;
    logic [2:0]  field_bytes_left;
    logic [31:0] pixel_start;
    logic [31:0] pixel_total;
    logic [31:0] pixels_out;
    logic        in_pixel_run;

    t_out_item   expected_results[$];
    t_out_item   want;
    t_out_item   predicted;
    int          fail_count  = 0;
    int          field_count = 0;
    int          pixel_count = 0;
    int          result_num  = 0;

    function automatic logic [2:0] field_length(input logic [2:0] id);
        return (id == FIELD_BITCOUNT) ? 3'd2 : 3'd4;
    endfunction

    task automatic find_field(input logic [31:0] offset, output logic hit, output logic [2:0] id);
        hit = 1'b1;
        id  = FIELD_SIZE;
        case (offset)
            32'd2:   id = FIELD_SIZE;
            32'd10:  id = FIELD_OFFSET;
            32'd14:  id = FIELD_HDRSIZE;
            32'd18:  id = FIELD_WIDTH;
            32'd22:  id = FIELD_HEIGHT;
            32'd28:  id = FIELD_BITCOUNT;
            32'd34:  id = FIELD_IMAGESIZE;
            default: hit = 1'b0;
        endcase
    endtask

    task automatic clear_parse_state();
        byte_pos         = '0;
        field_acc        = '0;
        cur_field        = FIELD_SIZE;
        field_bytes_left = '0;
        pixel_start      = '0;
        pixel_total      = '0;
        pixels_out       = '0;
        in_pixel_run     = 1'b0;
    endtask

    task automatic emit_pixel(input logic [7:0] b, inout t_out_item res);
        logic last;
        last            = (pixels_out + 32'd1 == pixel_total);
        res.kind        = KIND_PIXEL;
        res.pixel_byte  = b;
        res.pixel_index = pixels_out;
        res.last_pixel  = last;
        pixels_out      = pixels_out + 32'd1;
        if (last)
            in_pixel_run = 1'b0;
    endtask

    // one byte in, one result out
    task automatic parse_byte(input t_in_item item, output t_out_item res);
        logic [31:0] offset;
        logic        can_start;
        logic [2:0]  idx;
        logic        hit;
        logic [2:0]  id;
        res = '0;
        if (item.file_start)
            clear_parse_state();
        offset    = byte_pos;
        can_start = (byte_pos != POS_SATURATED);
        if (can_start)
            byte_pos = byte_pos + 32'd1;

        if (in_pixel_run) begin
            emit_pixel(item.data_byte, res);
        end else if (field_bytes_left != 3'd0) begin
            idx              = field_length(cur_field) - field_bytes_left;
            field_acc        = field_acc | ({24'd0, item.data_byte} << (8 * idx));
            field_bytes_left = field_bytes_left - 3'd1;
            if (field_bytes_left == 3'd0) begin
                if (cur_field == FIELD_OFFSET)
                    pixel_start = field_acc;
                if (cur_field == FIELD_IMAGESIZE)
                    pixel_total = field_acc;
                res.kind        = KIND_FIELD;
                res.field_id    = cur_field;
                res.field_value = field_acc;
            end
        end else if (can_start) begin
            find_field(offset, hit, id);
            if (hit) begin
                cur_field        = id;
                field_acc        = {24'd0, item.data_byte};
                field_bytes_left = field_length(id) - 3'd1;
            end else if (offset == pixel_start && pixel_total != 32'd0) begin
                in_pixel_run = 1'b1;
                pixels_out   = '0;
                emit_pixel(item.data_byte, res);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        fail_count++;
        if (fail_count <= PRINT_CAP)
            $display("MISMATCH result %0d %s: got 0x%0h, predicted 0x%0h",
                     result_num, what, got, exp_val);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parse_state();
            expected_results.delete();
        end else begin
            // result side first: a byte taken at this edge cannot have its result yet
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("with nothing pending, kind", 32'(i_out_data.kind), '0);
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_data.kind !== want.kind)
                        report_mismatch("kind", 32'(i_out_data.kind), 32'(want.kind));
                    if (i_out_data.field_id !== want.field_id)
                        report_mismatch("field_id", 32'(i_out_data.field_id), 32'(want.field_id));
                    if (i_out_data.field_value !== want.field_value)
                        report_mismatch("field_value", i_out_data.field_value, want.field_value);
                    if (i_out_data.pixel_byte !== want.pixel_byte)
                        report_mismatch("pixel_byte", 32'(i_out_data.pixel_byte),
                                        32'(want.pixel_byte));
                    if (i_out_data.pixel_index !== want.pixel_index)
                        report_mismatch("pixel_index", i_out_data.pixel_index, want.pixel_index);
                    if (i_out_data.last_pixel !== want.last_pixel)
                        report_mismatch("last_pixel", 32'(i_out_data.last_pixel),
                                        32'(want.last_pixel));
                    if (want.kind == KIND_FIELD)
                        field_count++;
                    if (want.kind == KIND_PIXEL)
                        pixel_count++;
                end
                result_num++;
            end
            if (i_in_valid && i_in_ready) begin
                parse_byte(i_in_data, predicted);
                expected_results.push_back(predicted);
            end
        end
        o_pending     = expected_results.size();
        o_fail_count  = fail_count;
        o_field_count = field_count;
        o_pixel_count = pixel_count;
    end

endmodule

FILE: test/bmp_header_stream_parser_unit_tb.sv
// Testbench top for the BMP header stream parser: file stimulus, flow control and verdict.
module bmp_header_stream_parser_unit_tb;
    import bhsp_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int RANDOM_ITEMS = 850;
    localparam int QUIET_FROM   = 400;
    localparam int QUIET_TO     = 700;
    localparam int HOLD_CYCLES  = 80;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic quiet;

    bhsp_in_if  in_ch();
    bhsp_out_if out_ch();

    int cycle_count   = 0;
    int results_taken = 0;
    int files_sent    = 0;
    int bytes_sent    = 0;
    int fail_count;
    int pending;
    int field_count;
    int pixel_count;

    logic [7:0] file_bytes[$];

    bmp_header_stream_parser_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    bmp_header_stream_parser_unit_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_ch.valid),
        .i_in_ready    (in_ch.ready),
        .i_in_data     (in_ch.data),
        .i_out_valid   (out_ch.valid),
        .i_out_ready   (out_ch.ready),
        .i_out_data    (out_ch.data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_field_count (field_count),
        .o_pixel_count (pixel_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // no random idling on either side inside this window
    assign quiet = (cycle_count >= QUIET_FROM) && (cycle_count < QUIET_TO);

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Run hit the cycle limit with %0d results pending", pending);
            $display("Some tests failed");
            $finish;
        end
    end

    // result receiver: random stalls plus two long hold-offs that back up the input
    initial begin : receiver
        int held;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                results_taken++;
                if (results_taken == 200 || results_taken == 600) begin
                    out_ch.ready <= 1'b0;
                    for (held = 0; held < HOLD_CYCLES; held++)
                        @(posedge i_clk);
                end
            end
            out_ch.ready <= quiet || ($urandom_range(0, 99) >= 14);
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic start);
        t_in_item item;
        item.data_byte  = b;
        item.file_start = start;
        while (!quiet && $urandom_range(0, 99) < 14) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= item;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_file();
        for (int i = 0; i < file_bytes.size(); i++)
            push_byte(file_bytes[i], i == 0);
        files_sent++;
    endtask

    // little-endian word into the file image, clipped at the file end
    task automatic put_word(input int at, input logic [31:0] v);
        for (int b = 0; b < 4; b++)
            if (at + b < file_bytes.size())
                file_bytes[at + b] = v[8 * b +: 8];
    endtask

    function automatic logic [31:0] pick_extreme();
        return ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
    endfunction

    task automatic build_file(input logic [31:0] pix_start, input logic [31:0] pix_count,
                              input int len);
        file_bytes.delete();
        for (int i = 0; i < len; i++)
            file_bytes.push_back(8'($urandom_range(0, 255)));
        put_word(10, pix_start);
        put_word(34, pix_count);
        if ($urandom_range(0, 3) == 0)
            put_word(2, pick_extreme());
        if ($urandom_range(0, 3) == 0)
            put_word(14, pick_extreme());
        if ($urandom_range(0, 3) == 0)
            put_word(18, pick_extreme());
        if ($urandom_range(0, 3) == 0)
            put_word(22, pick_extreme());
        if ($urandom_range(0, 3) == 0 && len > 29) begin
            file_bytes[28] = 8'(pick_extreme());
            file_bytes[29] = 8'(pick_extreme());
        end
    endtask

    initial begin : stimulus
        int          directed_bytes;
        int          mode;
        int          len;
        logic [31:0] pix_start;
        logic [31:0] pix_count;

        i_rst_n     = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // header extremes, offset field of zero with no image size
        file_bytes.delete();
        repeat (22) file_bytes.push_back(8'h00);
        file_bytes[0] = 8'hFF;
        put_word(2, 32'hFFFF_FFFF);
        put_word(6, 32'hFF00_FF00);
        put_word(10, 32'h0000_0000);
        put_word(14, 32'h8000_0001);
        put_word(18, 32'h0000_0000);
        send_file();
        // new file restarts while the size field is half assembled
        file_bytes.delete();
        repeat (4) file_bytes.push_back(8'($urandom_range(0, 255)));
        send_file();
        file_bytes.delete();
        file_bytes.push_back(8'h00);
        send_file();
        directed_bytes = bytes_sent;

        while (bytes_sent - directed_bytes < RANDOM_ITEMS) begin
            mode      = $urandom_range(0, 9);
            pix_count = $urandom_range(1, 24);
            if ($urandom_range(0, 7) == 0)
                pix_count = $urandom_range(25, 300);
            pix_start = $urandom_range(38, 80);
            len       = int'(pix_start + pix_count) + $urandom_range(0, 6);
            case (mode)
                0: begin
                    // zero image size: no pixel run
                    pix_count = '0;
                    len       = $urandom_range(38, 70);
                end
                1: begin
                    // data offset already behind the parser
                    pix_start = $urandom_range(0, 37);
                    len       = $urandom_range(38, 70);
                end
                2: begin
                    // data offset far beyond the file
                    pix_start = $urandom() | 32'h0001_0000;
                    len       = $urandom_range(38, 60);
                end
                3: len = $urandom_range(1, len);
                default: ;
            endcase
            if (mode == 4) begin
                // loose bytes with random restart marks
                repeat ($urandom_range(1, 6))
                    push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else begin
                build_file(pix_start, pix_count, len);
                send_file();
            end
        end

        in_ch.valid <= 1'b0;
        // sample the checker's count away from the edge it updates on
        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Streamed %0d files, %0d bytes in %0d cycles", files_sent, bytes_sent,
                 cycle_count);
        $display("Checked %0d results: %0d header fields, %0d pixel bytes", results_taken,
                 field_count, pixel_count);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
